// ===== src/four_channel_counter_timer_assert.svh =====
// Assertion macros used by the counter/timer RTL.
`ifndef FOUR_CHANNEL_COUNTER_TIMER_ASSERT_SVH
`define FOUR_CHANNEL_COUNTER_TIMER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FCCT_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define FCCT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== src/fcct_pkg.sv =====
// Types and constants of the four-channel counter/timer.
`default_nettype none

package fcct_pkg;

    localparam int NUM_CHAN = 4;

    // Operation codes of an input item
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_TRIG  = 3'd3;
    localparam logic [2:0] OP_MASK  = 3'd4;

    // Stored control bit positions
    localparam int CB_INT  = 4;
    localparam int CB_CNT  = 3;
    localparam int CB_PRE  = 2;
    localparam int CB_EDGE = 1;
    localparam int CB_TRG  = 0;

    // Control word bit positions
    localparam int CW_CTRL  = 0;
    localparam int CW_RESET = 1;
    localparam int CW_TC    = 2;
    localparam int CW_EDGE  = 4;

    typedef enum logic [2:0] {
        ST_RESET    = 3'd0,
        ST_RESET_TC = 3'd1,
        ST_TRIGGER  = 3'd2,
        ST_RUN      = 3'd3,
        ST_RUN_TC   = 3'd4,
        ST_AUTO     = 3'd5
    } t_chan_st;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] chan;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] zc_to_mask;
        logic [3:0] int_enable_mask;
    } t_out_item;

    typedef struct packed {
        logic [4:0] ctrl;
        logic [7:0] tc;
        logic [7:0] dc;
        logic [7:0] ps;
        t_chan_st   st;
        logic [1:0] cd;
    } t_chan;

    // Per-channel decode of the item being executed
    typedef struct packed {
        logic       write;
        logic       trig;
        logic       tick;
        logic       mask;
        logic       mask_bit;
        logic [7:0] data;
    } t_cmd;

endpackage

`default_nettype wire

// ===== src/fcct_chan.sv =====
// Next-state logic of one counter/timer channel for one item.
`default_nettype none

module fcct_chan (
    input  fcct_pkg::t_chan i_chan,
    input  fcct_pkg::t_cmd  i_cmd,
    input  logic            i_prev_fired,
    output fcct_pkg::t_chan o_chan,
    output logic            o_fired
);
    import fcct_pkg::*;

    t_chan chan_nx;

    always_comb begin
        t_chan      c;
        logic       fired;
        logic       wrap;
        logic       do_trig;
        logic       edge_chg;
        logic [7:0] v;
        t_chan_st   st;

        c        = i_chan;
        fired    = 1'b0;
        wrap     = 1'b0;
        do_trig  = i_cmd.trig;
        edge_chg = 1'b0;
        v        = i_cmd.data;
        st       = i_chan.st;

        if (i_cmd.write) begin
            if (st == ST_RESET_TC || st == ST_RUN_TC) begin
                // time constant byte
                c.tc = v;
                if (st == ST_RESET_TC) begin
                    c.dc = v;
                    c.ps = '0;
                    if (c.ctrl[CB_CNT]) begin
                        c.st = ST_RUN;
                    end else if (c.ctrl[CB_TRG]) begin
                        c.st = ST_TRIGGER;
                    end else begin
                        c.st = ST_AUTO;
                    end
                end else begin
                    c.st = ST_RUN;
                end
            end else if (v[CW_CTRL]) begin
                edge_chg = v[CW_EDGE] != c.ctrl[CB_EDGE];
                c.ctrl   = v[7:3];
                if (v[CW_RESET]) begin
                    c.st = v[CW_TC] ? ST_RESET_TC : ST_RESET;
                    c.ps = '0;
                    c.dc = c.tc;
                end else begin
                    if (v[CW_TC]) begin
                        case (st)
                            ST_RESET:              c.st = ST_RESET_TC;
                            ST_RUN:                c.st = ST_RUN_TC;
                            ST_TRIGGER, ST_AUTO:   c.st = ST_RESET_TC;
                            default:               c.st = st;
                        endcase
                    end
                    // an edge change acts as a trigger
                    if (edge_chg && (c.st == ST_TRIGGER || c.st == ST_RUN)) begin
                        if (c.st == ST_TRIGGER) begin
                            c.st = ST_RUN;
                        end
                        if (c.ctrl[CB_CNT]) begin
                            fired = c.dc == 8'd1;
                            c.dc  = fired ? c.tc : c.dc - 8'd1;
                        end
                    end
                end
            end
        end

        if (i_cmd.tick) begin
            if (!c.ctrl[CB_CNT]) begin
                if (c.st == ST_AUTO) begin
                    c.st = ST_RUN;
                    c.ps = '0;
                    c.dc = c.tc;
                end else if (c.st == ST_RUN || c.st == ST_RUN_TC) begin
                    c.ps = c.ps + 8'd1;
                    wrap = c.ctrl[CB_PRE] ? (c.ps == 8'd0) : (c.ps[3:0] == 4'd0);
                    if (wrap) begin
                        fired = c.dc == 8'd1;
                        c.dc  = fired ? c.tc : c.dc - 8'd1;
                    end
                end
            end
            // count down a pending chained trigger
            if (c.cd != 2'd0) begin
                c.cd = c.cd - 2'd1;
                if (c.cd == 2'd0) begin
                    do_trig = 1'b1;
                end
            end
        end

        if (do_trig) begin
            if (c.ctrl[CB_CNT]) begin
                if (c.st == ST_RUN || c.st == ST_RUN_TC) begin
                    fired = c.dc == 8'd1;
                    c.dc  = fired ? c.tc : c.dc - 8'd1;
                end
            end else if (c.st == ST_TRIGGER) begin
                c.st = ST_RUN;
                c.ps = '0;
            end
        end

        if (i_cmd.mask) begin
            c.ctrl[CB_INT] = i_cmd.mask_bit;
        end

        chan_nx = c;
        o_fired = fired;
    end

    // arm the chained trigger from the upstream channel
    always_comb begin
        o_chan = chan_nx;
        if (i_prev_fired) begin
            o_chan.cd = chan_nx.ctrl[CB_EDGE] ? 2'd1 : 2'd2;
        end
    end

endmodule

`default_nettype wire

// ===== src/four_channel_counter_timer.sv =====
// Four-channel counter/timer: an item is a bus write, a bus read, a clock tick, an
// external trigger or an interrupt-enable mask write, and each item gives one result
// with the read count, the channels that hit zero count and the enable bits. The
// block takes one item per cycle while the result side does not stall: an item is
// held in the input register, its whole effect on the four channels is computed
// from there, and the result is written to the output register when the item advances.
// Only a stall on the result side slows it down.
`default_nettype none

module four_channel_counter_timer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fcct_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fcct_pkg::t_out_item o_out_item
);
    import fcct_pkg::*;

    logic                     r_in_valid;
    t_in_item                 r_in;
    logic                     r_out_valid;
    t_out_item                r_out;
    t_chan [NUM_CHAN-1:0]     r_chan;
    t_chan [NUM_CHAN-1:0]     n_chan;
    t_cmd  [NUM_CHAN-1:0]     cmd;
    logic  [NUM_CHAN-1:0]     fired;
    logic                     advance;
    logic                     take;
    t_out_item                n_out;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign take       = i_in_valid && !o_in_stall;

    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_chan
        always_comb begin
            cmd[g].write    = r_in.op == OP_WRITE && r_in.chan == 2'(g);
            cmd[g].trig     = r_in.op == OP_TRIG && r_in.chan == 2'(g);
            cmd[g].tick     = r_in.op == OP_TICK;
            cmd[g].mask     = r_in.op == OP_MASK;
            cmd[g].mask_bit = r_in.data[g];
            cmd[g].data     = r_in.data;
        end

        fcct_chan u_chan (
            .i_chan       (r_chan[g]),
            .i_cmd        (cmd[g]),
            .i_prev_fired (fired[(g + NUM_CHAN - 1) % NUM_CHAN]),
            .o_chan       (n_chan[g]),
            .o_fired      (fired[g])
        );

        assign n_out.int_enable_mask[g] = n_chan[g].ctrl[CB_INT];
    end

    assign n_out.read_data  = (r_in.op == OP_READ) ? r_chan[r_in.chan].dc : 8'd0;
    assign n_out.zc_to_mask = fired;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHAN; i++) begin
                r_chan[i] <= '{ctrl: '0, tc: '0, dc: '0, ps: '0, st: ST_RESET, cd: '0};
            end
        end else begin
            r_in_valid  <= take || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && i_out_stall);
            if (advance) begin
                r_chan <= n_chan;
            end
        end
        if (take) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`include "four_channel_counter_timer_assert.svh"

    `FCCT_ASSERT_NEXT(a_hold_state, r_out_valid && i_out_stall, $stable(r_chan), "channel state moved while result held")
    `FCCT_ASSERT_NEXT(a_hold_item, o_in_stall, r_in_valid && $stable(r_in), "held item lost or changed")
    `FCCT_ASSERT_NEXT(a_chain_armed, advance && fired[0], r_chan[1].cd != 2'd0, "zero count of channel 0 did not arm channel 1")
    `FCCT_ASSERT_NOW(a_read_only, advance && r_in.op != OP_READ, n_out.read_data == 8'd0, "read data on a non-read item")

endmodule

`default_nettype wire
